### design/prc_pkg.sv
// shared constants, types and the arctangent table for the coordinate converter
package prc_pkg;

	// fraction bits kept below the input lsb in the datapath
	localparam int GUARD = 16;
	// right shift after the gain multiply, q0.31 constant down to GUARD fraction bits
	localparam int PRE_SHIFT = 31 - GUARD;
	// inverse cordic gain 0.607252935 in q0.31
	localparam logic signed [31:0] KINV_Q31 = 32'sd1304065748;
	// binary angle of pi in a 32-bit turn
	localparam logic [31:0] ANGLE_PI = 32'h8000_0000;

	typedef struct packed {
		logic mode;    // 0 vectoring, 1 rotation
		logic origin;  // vectoring item at x = y = 0
	} prc_ctl_t;

	// atan(2^-i) as a fraction of a full turn, 32-bit binary angle
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0: v = 32'h2000_0000;
			5'd1: v = 32'h12E4_051E;
			5'd2: v = 32'h09FB_385B;
			5'd3: v = 32'h0511_11D4;
			5'd4: v = 32'h028B_0D43;
			5'd5: v = 32'h0145_D7E1;
			5'd6: v = 32'h00A2_F61E;
			5'd7: v = 32'h0051_7C55;
			5'd8: v = 32'h0028_BE53;
			5'd9: v = 32'h0014_5F2F;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2FA;
			5'd15: v = 32'h0000_517D;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A30;
			5'd19: v = 32'h0000_0518;
			5'd20: v = 32'h0000_028C;
			5'd21: v = 32'h0000_0146;
			5'd22: v = 32'h0000_00A3;
			5'd23: v = 32'h0000_0051;
			5'd24: v = 32'h0000_0029;
			5'd25: v = 32'h0000_0014;
			5'd26: v = 32'h0000_000A;
			5'd27: v = 32'h0000_0005;
			5'd28: v = 32'h0000_0003;
			5'd29: v = 32'h0000_0001;
			5'd30: v = 32'h0000_0001;
			5'd31: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

### design/prc_if.sv
// valid/ready channel interfaces for converter input and result items
interface prc_in_if #(
	parameter int DATA_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [DATA_WIDTH-1:0] coord_a;
	logic signed [DATA_WIDTH-1:0] coord_b;

	modport source (output valid, output mode, output coord_a, output coord_b, input ready);
	modport sink (input valid, input mode, input coord_a, input coord_b, output ready);
endinterface

interface prc_out_if #(
	parameter int DATA_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH:0]   res_a;
	logic signed [DATA_WIDTH-1:0] res_b;

	modport source (output valid, output res_a, output res_b, input ready);
	modport sink (input valid, input res_a, input res_b, output ready);
endinterface

### design/prc_pre.sv
// front end: quadrant fold, start angle, then gain-compensating multiply
module prc_pre
	import prc_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int WORK_WIDTH = 34
) (
	input  logic                         clk,
	input  logic                         arst_n,
	prc_in_if.sink                       din,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output prc_ctl_t                     dn_ctl,
	output logic signed [WORK_WIDTH-1:0] dn_x,
	output logic signed [WORK_WIDTH-1:0] dn_y,
	output logic [31:0]                  dn_z
);

	localparam int ANG_SHIFT = 32 - DATA_WIDTH;
	localparam int PROD_WIDTH = DATA_WIDTH + 33;

	// stage 1 registers
	logic                         valid_s1;
	prc_ctl_t                     ctl_s1;
	logic signed [DATA_WIDTH:0]   a_s1;
	logic signed [DATA_WIDTH:0]   b_s1;
	logic [31:0]                  z_s1;
	// stage 2 registers
	logic                         valid_s2;
	prc_ctl_t                     ctl_s2;
	logic signed [WORK_WIDTH-1:0] x_s2;
	logic signed [WORK_WIDTH-1:0] y_s2;
	logic [31:0]                  z_s2;

	logic                         ready_s1;
	logic                         ready_s2;
	logic signed [DATA_WIDTH:0]   a_ext;
	logic signed [DATA_WIDTH:0]   b_ext;
	logic [31:0]                  zb;
	logic                         flip;
	prc_ctl_t                     ctl_d;
	logic signed [DATA_WIDTH:0]   a_d;
	logic signed [DATA_WIDTH:0]   b_d;
	logic [31:0]                  z_d;
	logic signed [PROD_WIDTH-1:0] pa;
	logic signed [PROD_WIDTH-1:0] pb;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign din.ready = ready_s1;

	assign a_ext = {din.coord_a[DATA_WIDTH-1], din.coord_a};
	assign b_ext = {din.coord_b[DATA_WIDTH-1], din.coord_b};
	assign zb    = 32'(unsigned'(din.coord_b)) << ANG_SHIFT;
	// angle outside [-pi/2, pi/2): top two bits differ
	assign flip  = zb[31] ^ zb[30];

	always_comb begin
		ctl_d.mode   = din.mode;
		ctl_d.origin = !din.mode && (din.coord_a == '0) && (din.coord_b == '0);
		a_d = a_ext;
		b_d = b_ext;
		z_d = '0;
		if (din.mode) begin
			z_d = zb;
			if (flip) begin
				a_d = -a_ext;
				z_d = zb ^ ANGLE_PI;
			end
		end else if (a_ext[DATA_WIDTH]) begin
			// left half plane: mirror the vector, start at pi
			a_d = -a_ext;
			b_d = -b_ext;
			z_d = ANGLE_PI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && din.valid) begin
			ctl_s1 <= ctl_d;
			a_s1   <= a_d;
			b_s1   <= b_d;
			z_s1   <= z_d;
		end
	end

	assign pa = a_s1 * KINV_Q31;
	assign pb = b_s1 * KINV_Q31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			x_s2   <= pa[PRE_SHIFT +: WORK_WIDTH];
			y_s2   <= ctl_s1.mode ? '0 : pb[PRE_SHIFT +: WORK_WIDTH];
			z_s2   <= z_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_ctl   = ctl_s2;
	assign dn_x     = x_s2;
	assign dn_y     = y_s2;
	assign dn_z     = z_s2;

endmodule

### design/prc_stage.sv
// one registered cordic micro-rotation, shift amount fixed per instance
module prc_stage
	import prc_pkg::*;
#(
	parameter int WORK_WIDTH = 34,
	parameter int IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  prc_ctl_t                     up_ctl,
	input  logic signed [WORK_WIDTH-1:0] up_x,
	input  logic signed [WORK_WIDTH-1:0] up_y,
	input  logic [31:0]                  up_z,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output prc_ctl_t                     dn_ctl,
	output logic signed [WORK_WIDTH-1:0] dn_x,
	output logic signed [WORK_WIDTH-1:0] dn_y,
	output logic [31:0]                  dn_z
);

	localparam logic [31:0] ATAN = atan_turn(5'(IDX));

	logic                         valid_s1;
	prc_ctl_t                     ctl_s1;
	logic signed [WORK_WIDTH-1:0] x_s1;
	logic signed [WORK_WIDTH-1:0] y_s1;
	logic [31:0]                  z_s1;

	logic                         cw;
	logic signed [WORK_WIDTH-1:0] xs;
	logic signed [WORK_WIDTH-1:0] ys;
	logic signed [WORK_WIDTH-1:0] nx;
	logic signed [WORK_WIDTH-1:0] ny;
	logic [31:0]                  nz;

	assign up_ready = !valid_s1 || dn_ready;

	assign xs = up_x >>> IDX;
	assign ys = up_y >>> IDX;
	// vectoring drives y to zero, rotation drives z to zero
	assign cw = up_ctl.mode ? up_z[31] : !up_y[WORK_WIDTH-1];

	always_comb begin
		if (cw) begin
			nx = up_x + ys;
			ny = up_y - xs;
			nz = up_z + ATAN;
		end else begin
			nx = up_x - ys;
			ny = up_y + xs;
			nz = up_z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			ctl_s1 <= up_ctl;
			x_s1   <= nx;
			y_s1   <= ny;
			z_s1   <= nz;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_ctl   = ctl_s1;
	assign dn_x     = x_s1;
	assign dn_y     = y_s1;
	assign dn_z     = z_s1;

endmodule

### design/prc_post.sv
// back end: round, saturate, angle rounding and the output register
module prc_post
	import prc_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int WORK_WIDTH = 34
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  prc_ctl_t                     up_ctl,
	input  logic signed [WORK_WIDTH-1:0] up_x,
	input  logic signed [WORK_WIDTH-1:0] up_y,
	input  logic [31:0]                  up_z,
	prc_out_if.source                    dout
);

	localparam int ANG_SHIFT = 32 - DATA_WIDTH;
	localparam int RW = WORK_WIDTH - GUARD;
	localparam logic [32:0] ANG_HALF = (33'd1 << ANG_SHIFT) >> 1;
	localparam logic signed [WORK_WIDTH-1:0] RND_HALF = WORK_WIDTH'(1) << (GUARD - 1);
	localparam logic signed [RW-1:0] A_MAX = RW'({DATA_WIDTH{1'b1}});
	localparam logic signed [RW-1:0] A_MIN = -(RW'(1) << DATA_WIDTH);
	localparam logic signed [RW-1:0] B_MAX = RW'({(DATA_WIDTH-1){1'b1}});
	localparam logic signed [RW-1:0] B_MIN = -(RW'(1) << (DATA_WIDTH - 1));

	logic                         valid_s1;
	logic signed [DATA_WIDTH:0]   res_a_s1;
	logic signed [DATA_WIDTH-1:0] res_b_s1;

	logic signed [WORK_WIDTH-1:0] xr;
	logic signed [WORK_WIDTH-1:0] yr;
	logic signed [RW-1:0]         rx;
	logic signed [RW-1:0]         ry;
	logic [32:0]                  zsum;
	logic signed [DATA_WIDTH:0]   sat_a;
	logic signed [DATA_WIDTH-1:0] sat_b;
	logic signed [DATA_WIDTH:0]   res_a_d;
	logic signed [DATA_WIDTH-1:0] res_b_d;

	assign up_ready = !valid_s1 || dout.ready;

	// round half up to the input lsb
	assign xr = up_x + RND_HALF;
	assign yr = up_y + RND_HALF;
	assign rx = xr[WORK_WIDTH-1:GUARD];
	assign ry = yr[WORK_WIDTH-1:GUARD];
	assign zsum = {1'b0, up_z} + ANG_HALF;

	always_comb begin
		if (rx > A_MAX) begin
			sat_a = A_MAX[DATA_WIDTH:0];
		end else if (rx < A_MIN) begin
			sat_a = A_MIN[DATA_WIDTH:0];
		end else begin
			sat_a = rx[DATA_WIDTH:0];
		end
		if (ry > B_MAX) begin
			sat_b = B_MAX[DATA_WIDTH-1:0];
		end else if (ry < B_MIN) begin
			sat_b = B_MIN[DATA_WIDTH-1:0];
		end else begin
			sat_b = ry[DATA_WIDTH-1:0];
		end
	end

	always_comb begin
		if (up_ctl.origin) begin
			res_a_d = '0;
			res_b_d = '0;
		end else if (up_ctl.mode) begin
			res_a_d = sat_a;
			res_b_d = sat_b;
		end else begin
			res_a_d = sat_a;
			res_b_d = zsum[ANG_SHIFT +: DATA_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_a_s1 <= res_a_d;
			res_b_s1 <= res_b_d;
		end
	end

	assign dout.valid = valid_s1;
	assign dout.res_a = res_a_s1;
	assign dout.res_b = res_b_s1;

endmodule

### design/polar_rectangular_converter.sv
// throughput: one item per cycle unless the result stalls; two front-end stages, one
// cordic stage per iteration, one output stage, each with its own valid bit
// a stalled result only holds back the stages behind it, bubbles close up
// reset clears every valid bit; datapath registers are not reset
module polar_rectangular_converter
	import prc_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int ITERATIONS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	prc_in_if.sink     din,
	prc_out_if.source  dout
);

	// headroom for the vector magnitude and cordic growth
	localparam int WORK_WIDTH = DATA_WIDTH + GUARD + 2;

	logic                         valid_p [ITERATIONS+1];
	logic                         ready_p [ITERATIONS+1];
	prc_ctl_t                     ctl_p   [ITERATIONS+1];
	logic signed [WORK_WIDTH-1:0] x_p     [ITERATIONS+1];
	logic signed [WORK_WIDTH-1:0] y_p     [ITERATIONS+1];
	logic [31:0]                  z_p     [ITERATIONS+1];

	prc_pre #(
		.DATA_WIDTH (DATA_WIDTH),
		.WORK_WIDTH (WORK_WIDTH)
	) u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.dn_valid (valid_p[0]),
		.dn_ready (ready_p[0]),
		.dn_ctl   (ctl_p[0]),
		.dn_x     (x_p[0]),
		.dn_y     (y_p[0]),
		.dn_z     (z_p[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		prc_stage #(
			.WORK_WIDTH (WORK_WIDTH),
			.IDX        (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_p[i]),
			.up_ready (ready_p[i]),
			.up_ctl   (ctl_p[i]),
			.up_x     (x_p[i]),
			.up_y     (y_p[i]),
			.up_z     (z_p[i]),
			.dn_valid (valid_p[i+1]),
			.dn_ready (ready_p[i+1]),
			.dn_ctl   (ctl_p[i+1]),
			.dn_x     (x_p[i+1]),
			.dn_y     (y_p[i+1]),
			.dn_z     (z_p[i+1])
		);
	end

	prc_post #(
		.DATA_WIDTH (DATA_WIDTH),
		.WORK_WIDTH (WORK_WIDTH)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_p[ITERATIONS]),
		.up_ready (ready_p[ITERATIONS]),
		.up_ctl   (ctl_p[ITERATIONS]),
		.up_x     (x_p[ITERATIONS]),
		.up_y     (y_p[ITERATIONS]),
		.up_z     (z_p[ITERATIONS]),
		.dout     (dout)
	);

endmodule
